@@ rtl/core/stb_pkg.sv @@
// ----------------------------------------------------------------------------
// stb_pkg
// shared widths, command and result codes for the software timer bank
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int TIMER_COUNT = 16;
  localparam int IDX_W       = 4;
  localparam int TAG_W       = 8;
  localparam int CNT_W       = 32;
  localparam int CMD_W       = 2;
  localparam int KIND_W      = 2;

  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 16;

  // commands carried in tuser of the input stream
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STOP   = 2'd3;

  // result kinds carried in tuser of the output stream
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IDLE   = 2'd2;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_BAD = 1'b1;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             urgent;
    logic [IDX_W-1:0] index;
  } expiry_t;

endpackage

@@ rtl/core/software_timer_bank_core.sv @@
// ----------------------------------------------------------------------------
// software_timer_bank_core
// bank of count-down timers driven by create, start, stop and tick commands
// ----------------------------------------------------------------------------
// flow: create, start and stop register the status transaction, seen in the
//   cycle after acceptance; a tick walks the timers through one shared
//   decrementer in S_SWEEP, one timer per cycle unless a second expiry waits
//   on a busy output, then sends its last result from S_FLUSH
// input: one command per cycle while results are taken, none during a tick
// reset: rst (sync, active high) clears all flags, tags and valid of output
// ----------------------------------------------------------------------------
module software_timer_bank_core (
  input  logic                           clk,
  input  logic                           rst,
  // input stream, tuser: cmd
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // tdata from bit 0: timer_index, one_shot, urgent, load_ms, tag_present,
  // tag_value, zero fill
  input  logic [stb_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [stb_pkg::CMD_W-1:0]      s_tuser,
  // output stream, tuser: kind, tlast: last
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // tdata from bit 0: status, expired_index, expired_urgent, expired_tag,
  // zero fill
  output logic [stb_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [stb_pkg::KIND_W-1:0]     m_tuser,
  output logic                           m_tlast
);

  import stb_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state;

  // per-timer flags, cleared by reset
  logic [TIMER_COUNT-1:0] created;
  logic [TIMER_COUNT-1:0] active;
  logic [TIMER_COUNT-1:0] one_shot;
  logic [TIMER_COUNT-1:0] urgent;

  // per-timer storage; counts are only read while active, which a start
  // always precedes with a write of both
  logic [CNT_W-1:0] remaining [TIMER_COUNT];
  logic [CNT_W-1:0] reload    [TIMER_COUNT];
  logic [TAG_W-1:0] tag_store [TIMER_COUNT];

  // sweep pointer and the expiry held back until we know whether it is last
  logic [IDX_W-1:0] ptr;
  logic             pend_valid;
  expiry_t          pend;

  // input field unpacking
  logic [IDX_W-1:0] in_index;
  logic             in_one_shot;
  logic             in_urgent;
  logic [CNT_W-1:0] in_load;
  logic             in_tag_present;
  logic [TAG_W-1:0] in_tag;

  assign in_index       = s_tdata[3:0];
  assign in_one_shot    = s_tdata[4];
  assign in_urgent      = s_tdata[5];
  assign in_load        = s_tdata[37:6];
  assign in_tag_present = s_tdata[38];
  assign in_tag         = s_tdata[46:39];

  logic out_free;
  logic in_accept;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;
  assign in_accept = s_tvalid && s_tready;

  // shared decrement unit on the timer under the pointer
  logic [CNT_W-1:0] cur_count;
  logic [CNT_W-1:0] dec_count;
  logic             cur_live;
  logic             cur_expires;
  logic             step_ok;
  expiry_t          cur_expiry;

  assign cur_count   = remaining[ptr];
  assign dec_count   = cur_count - CNT_W'(1);
  assign cur_live    = active[ptr] && (cur_count != '0);
  assign cur_expires = cur_live && (dec_count == '0);
  // a second expiry pushes the held one out, which needs the output slot
  assign step_ok     = !(cur_expires && pend_valid) || out_free;

  assign cur_expiry.index  = ptr;
  assign cur_expiry.urgent = urgent[ptr];
  assign cur_expiry.tag    = tag_store[ptr];

  // status result for a command
  logic cmd_status;

  always_comb begin
    cmd_status = ST_OK;
    unique case (s_tuser)
      CMD_CREATE: if (active[in_index]) cmd_status = ST_BAD;
      CMD_START:  if (!created[in_index]) cmd_status = ST_BAD;
      default:    cmd_status = ST_OK;
    endcase
  end

  // a new output transaction is loaded this cycle
  logic out_load;

  assign out_load = ((state == S_IDLE) && in_accept && (s_tuser != CMD_TICK))
                 || ((state == S_SWEEP) && step_ok && cur_expires && pend_valid)
                 || ((state == S_FLUSH) && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      created    <= '0;
      active     <= '0;
      one_shot   <= '0;
      urgent     <= '0;
      ptr        <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        tag_store[i] <= '0;
      end
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (s_tuser == CMD_TICK) begin
              state      <= S_SWEEP;
              ptr        <= '0;
              pend_valid <= 1'b0;
            end else begin
              m_tuser  <= KIND_STATUS;
              m_tdata  <= {{(OUT_DATA_W-1){1'b0}}, cmd_status};
              m_tlast  <= 1'b1;
              unique case (s_tuser)
                CMD_CREATE: begin
                  if (!active[in_index]) begin
                    one_shot[in_index] <= in_one_shot;
                    urgent[in_index]   <= in_urgent;
                    created[in_index]  <= 1'b1;
                  end
                end
                CMD_START: begin
                  if (created[in_index]) begin
                    remaining[in_index] <= in_load;
                    reload[in_index]    <= in_load;
                    if (in_tag_present) tag_store[in_index] <= in_tag;
                    active[in_index] <= 1'b1;
                  end
                end
                default: active[in_index] <= 1'b0;
              endcase
            end
          end
        end

        S_SWEEP: begin
          if (step_ok) begin
            if (cur_live) begin
              if (!cur_expires) begin
                remaining[ptr] <= dec_count;
              end else if (one_shot[ptr]) begin
                remaining[ptr] <= dec_count;
                active[ptr]    <= 1'b0;
              end else begin
                remaining[ptr] <= reload[ptr];
              end
            end
            if (cur_expires) begin
              if (pend_valid) begin
                // earlier expiry is now known not to be the last one
                m_tuser  <= KIND_EXPIRY;
                m_tdata  <= {2'b00, pend, ST_OK};
                m_tlast  <= 1'b0;
              end
              pend       <= cur_expiry;
              pend_valid <= 1'b1;
            end
            if (ptr == IDX_W'(TIMER_COUNT - 1)) begin
              state <= S_FLUSH;
            end else begin
              ptr <= ptr + IDX_W'(1);
            end
          end
        end

        S_FLUSH: begin
          if (out_free) begin
            m_tlast  <= 1'b1;
            if (pend_valid) begin
              m_tuser <= KIND_EXPIRY;
              m_tdata <= {2'b00, pend, ST_OK};
            end else begin
              m_tuser <= KIND_IDLE;
              m_tdata <= '0;
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/software_timer_bank_core_tb.sv @@
// ----------------------------------------------------------------------------
// software_timer_bank_core_tb
// self-checking bench: streams create, start, stop and tick commands into the
// timer bank, predicts every status, expiry and idle transaction from a
// behavioural copy of the bank and compares each output transaction in order
// ----------------------------------------------------------------------------
package timer_bank_tb_pkg;
  import stb_pkg::*;

  // one output transaction, fields as the bank reports them
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              status;
    logic [IDX_W-1:0]  index;
    logic              urgent;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } timer_result_t;

  class timer_bank_scoreboard;
    // behavioural copy of the bank
    bit             is_created  [TIMER_COUNT];
    bit             is_active   [TIMER_COUNT];
    bit             is_one_shot [TIMER_COUNT];
    bit             is_urgent   [TIMER_COUNT];
    bit [CNT_W-1:0] count_left  [TIMER_COUNT];
    bit [CNT_W-1:0] count_reload[TIMER_COUNT];
    bit [TAG_W-1:0] timer_tag   [TIMER_COUNT];

    timer_result_t awaited[$];

    int mismatches;
    int commands;
    int checked;
    int expiries;
    int idle_ticks;
    int rejected;
    int widest_tick;

    function void note_mismatch(string what, timer_result_t want,
                                timer_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch %0d (%s): expected kind %0d status %0d index %0d urgent %0d",
                 mismatches, what, want.kind, want.status, want.index, want.urgent);
        $display("  expected tag %02h last %0d, got kind %0d status %0d index %0d",
                 want.tag, want.last, got.kind, got.status, got.index);
        $display("  got urgent %0d tag %02h last %0d", got.urgent, got.tag, got.last);
      end
    endfunction

    // works out the transactions one accepted command causes
    function void note_item(logic [CMD_W-1:0] cmd, logic [IN_DATA_W-1:0] data);
      logic [IDX_W-1:0] idx;
      logic             os;
      logic             urg;
      logic [CNT_W-1:0] load;
      logic             tp;
      logic [TAG_W-1:0] tv;
      timer_result_t    res;
      timer_result_t    burst[$];
      idx  = data[IDX_W-1:0];
      os   = data[IDX_W];
      urg  = data[IDX_W+1];
      load = data[IDX_W+2 +: CNT_W];
      tp   = data[IDX_W+2+CNT_W];
      tv   = data[IDX_W+3+CNT_W +: TAG_W];
      res  = '0;
      commands++;
      if (cmd == CMD_TICK) begin
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (is_active[i] && count_left[i] != 0) begin
            count_left[i]--;
            if (count_left[i] == 0) begin
              if (is_one_shot[i])
                is_active[i] = 1'b0;
              else
                count_left[i] = count_reload[i];
              res.kind   = KIND_EXPIRY;
              res.status = ST_OK;
              res.index  = IDX_W'(i);
              res.urgent = is_urgent[i];
              res.tag    = timer_tag[i];
              res.last   = 1'b0;
              if (burst.size() < TIMER_COUNT)
                burst.push_back(res);
            end
          end
        end
        if (burst.size() == 0) begin
          res      = '0;
          res.kind = KIND_IDLE;
          res.last = 1'b1;
          burst.push_back(res);
          idle_ticks++;
        end else begin
          res = burst.pop_back();
          res.last = 1'b1;
          burst.push_back(res);
          expiries += burst.size();
          if (burst.size() > widest_tick)
            widest_tick = burst.size();
        end
        foreach (burst[k])
          awaited.push_back(burst[k]);
      end else begin
        res.kind   = KIND_STATUS;
        res.status = ST_OK;
        res.last   = 1'b1;
        case (cmd)
          CMD_CREATE: begin
            if (is_active[idx]) begin
              res.status = ST_BAD;
            end else begin
              is_one_shot[idx] = os;
              is_urgent[idx]   = urg;
              is_created[idx]  = 1'b1;
            end
          end
          CMD_START: begin
            if (!is_created[idx]) begin
              res.status = ST_BAD;
            end else begin
              count_left[idx]   = load;
              count_reload[idx] = load;
              if (tp)
                timer_tag[idx] = tv;
              is_active[idx] = 1'b1;
            end
          end
          default: begin
            is_active[idx] = 1'b0;
          end
        endcase
        if (res.status == ST_BAD)
          rejected++;
        awaited.push_back(res);
      end
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t want;
      checked++;
      if (awaited.size() == 0) begin
        note_mismatch("nothing expected", '0, got);
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind || got.status !== want.status ||
          got.index !== want.index || got.urgent !== want.urgent ||
          got.tag !== want.tag || got.last !== want.last)
        note_mismatch("field differs", want, got);
    endfunction
  endclass
endpackage

module software_timer_bank_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stb_pkg::*;
  import timer_bank_tb_pkg::*;

  // cycles with no transaction on either side before the run is given up
  localparam int QUIET_LIMIT  = 4000;
  // long receiver hold-off that lets the bank fill up and stall its input
  localparam int HOLD_CYCLES  = 400;
  // settling time after the last expected transaction, beyond a full sweep
  localparam int DRAIN_CYCLES = 40;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [CMD_W-1:0]      s_tuser  = CMD_TICK;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;

  int send_idle_pct   = 0;
  int ready_stall_pct = 0;
  bit hold_request    = 1'b0;
  int quiet_cycles    = 0;

  timer_bank_scoreboard sb = new();

  // output transaction unpacked into its fields, kind from tuser, last from tlast
  timer_result_t out_item;
  assign out_item = {m_tuser, m_tdata[0], m_tdata[4:1], m_tdata[5], m_tdata[13:6], m_tlast};

  always #4 clk = ~clk;

  software_timer_bank_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // timer_index, one_shot, urgent, load_ms, tag_present, tag_value
    .s_tuser  (s_tuser),   // cmd
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // status, expired_index, expired_urgent, expired_tag
    .m_tuser  (m_tuser),   // kind
    .m_tlast  (m_tlast)    // last
  );

  // monitor and watchdog: values read here are the ones the bank saw at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_item(s_tuser, s_tdata);
      if (m_tvalid && m_tready)
        sb.check_result(out_item);
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d still expected",
               quiet_cycles, sb.awaited.size());
      $display("[software_timer_bank_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= ready_stall_pct);
      end
    end
  end

  // random content for the fields a command does not use
  function automatic logic [IN_DATA_W-1:0] noise_bits();
    logic [IN_DATA_W-1:0] d;
    d = IN_DATA_W'({$urandom, $urandom});
    d[IN_DATA_W-1] = 1'b0;
    return d;
  endfunction

  // offers one transaction, called at a rising edge, returns at the edge it is taken
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IN_DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, noise_bits());
  endtask

  task automatic send_create(input logic [IDX_W-1:0] idx, input logic os, input logic urg);
    logic [IN_DATA_W-1:0] d;
    d = noise_bits();
    d[IDX_W-1:0] = idx;
    d[IDX_W]     = os;
    d[IDX_W+1]   = urg;
    send_item(CMD_CREATE, d);
  endtask

  task automatic send_start(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] load,
                            input logic tp, input logic [TAG_W-1:0] tv);
    logic [IN_DATA_W-1:0] d;
    d = noise_bits();
    d[IDX_W-1:0]                 = idx;
    d[IDX_W+2 +: CNT_W]          = load;
    d[IDX_W+2+CNT_W]             = tp;
    d[IDX_W+3+CNT_W +: TAG_W]    = tv;
    send_item(CMD_START, d);
  endtask

  task automatic send_stop(input logic [IDX_W-1:0] idx);
    logic [IN_DATA_W-1:0] d;
    d = noise_bits();
    d[IDX_W-1:0] = idx;
    send_item(CMD_STOP, d);
  endtask

  // mostly short counts so timers really expire, now and then zero or huge
  function automatic logic [CNT_W-1:0] pick_load();
    int r;
    r = $urandom_range(99);
    if (r < 8)
      return '0;
    else if (r < 14)
      return $urandom;
    else if (r < 17)
      return '1;
    else
      return $urandom_range(6, 1);
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 40)
      send_tick();
    else if (r < 58)
      send_create(IDX_W'($urandom_range(TIMER_COUNT - 1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    else if (r < 80)
      send_start(IDX_W'($urandom_range(TIMER_COUNT - 1)), pick_load(),
                 1'($urandom_range(1)), TAG_W'($urandom_range(255)));
    else if (r < 92)
      send_stop(IDX_W'($urandom_range(TIMER_COUNT - 1)));
    else
      send_item(CMD_W'($urandom_range(3)), noise_bits());   // anything at all
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    send_idle_pct   = idle_pct;
    ready_stall_pct = stall_pct;
    repeat (n) random_item();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part, no idling on either side
    send_tick();                          // empty bank: idle tick
    send_start(4'd3, 32'd5, 1'b1, 8'hA5); // never created: rejected
    send_stop(4'd15);                     // stop of an idle timer is fine
    send_create(4'd0, 1'b1, 1'b1);        // one-shot, urgent
    send_start(4'd0, 32'd1, 1'b1, 8'hFF);
    send_create(4'd0, 1'b0, 1'b0);        // create while active: rejected
    send_tick();                          // one-shot expiry, timer drops out
    send_tick();                          // nothing left: idle
    send_create(4'd0, 1'b0, 1'b0);        // create again while inactive
    send_start(4'd0, '0, 1'b0, 8'h00);    // zero load: active but never counts
    send_tick();
    send_create(4'd15, 1'b0, 1'b1);
    send_start(4'd15, '1, 1'b1, 8'h00);   // largest count
    send_create(4'd7, 1'b0, 1'b0);
    send_start(4'd7, 32'd2, 1'b1, 8'h5A); // periodic every second tick
    send_tick();
    send_tick();
    send_start(4'd7, 32'd2, 1'b0, 8'hC3); // restart without tag keeps 5a
    send_tick();
    send_tick();
    send_stop(4'd7);
    send_tick();
    send_stop(4'd0);

    // whole bank armed at count one so one tick expires every timer, while the
    // receiver holds off long enough for the bank to back up into its input
    hold_request = 1'b1;
    for (int i = 0; i < TIMER_COUNT; i++) begin
      send_create(IDX_W'(i), 1'($urandom_range(1)), 1'($urandom_range(1)));
      send_start(IDX_W'(i), 32'd1, 1'b1, TAG_W'($urandom_range(255)));
    end
    send_tick();

    run_phase(0, 0, 12);
    run_phase(80, 0, 22);
    run_phase(0, 80, 22);
    run_phase(33, 33, 22);

    s_tvalid        <= 1'b0;
    ready_stall_pct = 0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d commands (%0d rejected) and %0d output transactions checked",
             sb.commands, sb.rejected, sb.checked);
    $display("ticks gave %0d expiries, up to %0d in one tick, and %0d idle ticks; %0d mismatches",
             sb.expiries, sb.widest_tick, sb.idle_ticks, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("[software_timer_bank_core] OK");
    end else begin
      $display("[software_timer_bank_core] ERROR");
    end
    $finish;
  end
endmodule
